// File: design/assert_macros.svh
// assertion macros used by the design files
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("implication check failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/ssdg_pkg.sv
// shared types and constants of the step/direction generator
// no dependencies; imported by every design file
package ssdg_pkg;

    // sizes
    localparam int POSITION_BITS  = 40;
    localparam int MAX_BURST      = 64;
    localparam int BURST_BITS     = $clog2(MAX_BURST + 1);
    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int FRONT_DEPTH    = 2;
    localparam int FRONT_PTR_BITS = $clog2(FRONT_DEPTH);
    localparam int OUT_DEPTH      = 2;
    localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);

    // register reset values
    localparam logic [31:0] SPD_RESET   = 32'd65536;
    localparam logic [31:0] RATE_RESET  = 32'd66;
    localparam logic [6:0]  BURST_RESET = 7'd1;
    localparam logic [31:0] UNITY_Q16   = 32'h0001_0000;
    localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_8000_0000;

    // division by the millisecond scale, 16-bit digits, reciprocal multiply
    localparam int RATE_DIVISOR = 1000;
    localparam int DIGIT_BITS   = 16;
    localparam int NUM_DIGITS   = 64 / DIGIT_BITS;
    localparam int DIGIT_CNT_BITS = $clog2(NUM_DIGITS);
    localparam int REM_BITS     = $clog2(RATE_DIVISOR);
    localparam int DIV_X_BITS   = REM_BITS + DIGIT_BITS;
    localparam int DIV_SHIFT    = 36;
    localparam logic [31:0] DIV_RECIP =
        32'(((64'd1 << DIV_SHIFT) + 64'(RATE_DIVISOR) - 64'd1) / 64'(RATE_DIVISOR));

    // item function codes
    typedef enum logic [1:0] {
        FUNC_TICK         = 2'd0,
        FUNC_SET_TARGET   = 2'd1,
        FUNC_SET_POSITION = 2'd2,
        FUNC_STOP         = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_STEPS_PER_DEGREE = 2'd0,
        REG_STEPS_PER_MS     = 2'd1,
        REG_MAX_STEPS        = 2'd2
    } cfg_addr_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_START,
        BK_AMUL,
        BK_ANGLE,
        BK_TMUL,
        BK_DLOAD,
        BK_DSET,
        BK_DWAIT,
        BK_DSTEP,
        BK_ALLOW,
        BK_BURST,
        BK_STATUS
    } back_state_t;

    // input word
    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        now_ms;
        logic signed [31:0] angle_deg_q16;
    } item_t;

    // result word
    typedef struct packed {
        logic                            step;
        logic                            direction;
        logic                            enable;
        logic signed [POSITION_BITS-1:0] position_steps;
        logic                            last;
    } result_t;

    // classified word from front to back
    typedef struct packed {
        func_t       op;
        logic [31:0] now_ms;
        logic        angle_neg;
        logic [31:0] angle_mag;
    } cmd_t;

    // configuration registers
    typedef struct packed {
        logic [31:0] steps_per_degree_q16;
        logic [31:0] steps_per_ms_q16;
        logic [6:0]  max_steps_per_update;
    } cfg_t;

    // back-end status
    typedef struct packed {
        logic idle;
        logic in_burst;
    } back_status_t;

endpackage

// File: design/stepper_step_dir_generator.sv
// top level of the step/direction generator: configuration registers and
// the front end, back end and result queue; uses ssdg_pkg and assert_macros.svh
//
// Input words enter through push/full and results leave through empty/pop,
// both as queues. Every input word gives at least one result word; a tick
// that moves the axis gives one word per step, the final one marked last.
// The status word of a stop, a first tick or an idle tick is made in the back-end
// states start and status; set target and set position, which go through the
// shared multiplier, first pass the states for the product and the angle. Any other
// tick first runs the division by 1000 in four 16-bit digits through the same
// multiplier, then gives one step per cycle while the result queue has room.
// Words are carried out one at a time; two more wait in the input queue.
// When the receiver stops popping, the two-word result queue fills and the
// back end holds, then the input queue fills and full rises. No word is lost.
// Reset clears position, target, fraction, time, direction and enable, and loads
// the register defaults; pready is always high. Registers are written over the APB
// port at byte addresses 0, 4 and 8 while the block is idle (the user's duty, not enforced).
`include "assert_macros.svh"

module stepper_step_dir_generator
    import ssdg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  item_t                    item,
    output logic                     empty,
    input  logic                     pop,
    output result_t                  result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [31:0]  cfg_spd_reg;
    logic [31:0]  cfg_rate_reg;
    logic [6:0]   cfg_burst_reg;
    logic         cfg_wr;
    cfg_t         cfg;
    logic         cmd_valid;
    cmd_t         cmd;
    logic         cmd_pop;
    logic         res_wr;
    logic         res_full;
    result_t      res_word;
    back_status_t back_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_spd_reg   <= SPD_RESET;
            cfg_rate_reg  <= RATE_RESET;
            cfg_burst_reg <= BURST_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr_t'(paddr[CFG_ADDR_BITS-1:2]))
                REG_STEPS_PER_DEGREE: cfg_spd_reg   <= pwdata;
                REG_STEPS_PER_MS:     cfg_rate_reg  <= pwdata;
                REG_MAX_STEPS:        cfg_burst_reg <= pwdata[6:0];
                default:              ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_addr_t'(paddr[CFG_ADDR_BITS-1:2]))
            REG_STEPS_PER_DEGREE: prdata = cfg_spd_reg;
            REG_STEPS_PER_MS:     prdata = cfg_rate_reg;
            REG_MAX_STEPS:        prdata = CFG_DATA_BITS'(cfg_burst_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.steps_per_degree_q16 = cfg_spd_reg;
    assign cfg.steps_per_ms_q16     = cfg_rate_reg;
    assign cfg.max_steps_per_update = cfg_burst_reg;

    // input queue and classification
    ssdg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // sequencer
    ssdg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res_word  (res_word),
        .status    (back_stat)
    );

    // result queue
    ssdg_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_word (res_word),
        .wr_full (res_full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // checks
    `ASSERT_IMPLY(a_res_no_overflow, clk, rst_n, res_wr, !res_full)
    `ASSERT_NEXT(a_push_reaches_back, clk, rst_n, push && !full, cmd_valid)
    `ASSERT_IMPLY(a_step_only_in_burst, clk, rst_n, res_wr && res_word.step, back_stat.in_burst)
    `ASSERT_IMPLY(a_mid_burst_enabled, clk, rst_n,
                  res_wr && res_word.step && !res_word.last, res_word.enable)

endmodule

// File: design/ssdg_front.sv
// front end: accepts input words, splits the angle into sign and magnitude,
// and holds them in a short queue for the back end; uses ssdg_pkg
module ssdg_front
    import ssdg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cmd_valid,
    output cmd_t  cmd,
    input  logic  cmd_pop
);

    cmd_t                    q_reg [FRONT_DEPTH];
    logic [FRONT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FRONT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FRONT_PTR_BITS:0]   count_reg, count_next;
    logic                      push_ok;
    logic                      pop_ok;
    cmd_t                      in_cmd;

    // classify the incoming word
    always_comb
    begin
        in_cmd.op        = func_t'(item.func);
        in_cmd.now_ms    = item.now_ms;
        in_cmd.angle_neg = item.angle_deg_q16[31];
        in_cmd.angle_mag = item.angle_deg_q16[31] ? (~item.angle_deg_q16 + 32'd1)
                                                  : item.angle_deg_q16;
    end

    assign full      = (count_reg == (FRONT_PTR_BITS + 1)'(FRONT_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + FRONT_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + FRONT_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + (FRONT_PTR_BITS + 1)'(push_ok)
                                - (FRONT_PTR_BITS + 1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: design/ssdg_back.sv
// back end: sequencer that carries out one classified word at a time,
// with one shared 32x32 multiplier; uses ssdg_pkg
module ssdg_back
    import ssdg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         cmd_valid,
    input  cmd_t         cmd,
    output logic         cmd_pop,
    input  logic         res_full,
    output logic         res_wr,
    output result_t      res_word,
    output back_status_t status
);

    back_state_t state_reg, state_next;

    logic signed [POSITION_BITS-1:0] pos_reg, pos_next;
    logic signed [POSITION_BITS-1:0] target_reg, target_next;
    logic [15:0]                     frac_reg, frac_next;
    logic [31:0]                     last_time_reg, last_time_next;
    logic                            dir_reg, dir_next;
    logic                            en_reg, en_next;

    cmd_t                      cmd_reg, cmd_next;
    logic [31:0]               mul_a_reg, mul_a_next;
    logic [31:0]               mul_b_reg, mul_b_next;
    logic [63:0]               prod_reg, prod_next;
    logic [63:0]               dvd_reg, dvd_next;
    logic [REM_BITS-1:0]       rem_reg, rem_next;
    logic [DIV_X_BITS-1:0]     x_reg, x_next;
    logic [63:0]               quot_reg, quot_next;
    logic [DIGIT_CNT_BITS-1:0] dig_reg, dig_next;
    logic [BURST_BITS-1:0]     cnt_reg, cnt_next;

    logic [31:0]                     spd_eff;
    logic [31:0]                     rate_eff;
    logic [6:0]                      burst_eff;
    logic [31:0]                     elapsed;
    logic [63:0]                     rnd;
    logic signed [32:0]              steps33;
    logic signed [POSITION_BITS-1:0] angle_steps;
    logic [DIGIT_BITS-1:0]           q_digit;
    logic [63:0]                     allow;
    logic [47:0]                     n_raw;
    logic [BURST_BITS-1:0]           lim;
    logic [BURST_BITS-1:0]           n_lim;
    logic                            fwd;
    logic signed [POSITION_BITS:0]   diff;
    logic [POSITION_BITS:0]          dist_left;
    logic signed [POSITION_BITS-1:0] step_pos;
    logic                            fin;

    // zero register values act as unity in q16.16 for the two scales and as one step for the burst limit
    assign spd_eff   = (cfg.steps_per_degree_q16 == '0) ? UNITY_Q16 : cfg.steps_per_degree_q16;
    assign rate_eff  = (cfg.steps_per_ms_q16 == '0) ? UNITY_Q16 : cfg.steps_per_ms_q16;
    assign burst_eff = (cfg.max_steps_per_update == '0) ? 7'd1 : cfg.max_steps_per_update;

    // shared multiplier, registered product
    assign prod_next = 64'(mul_a_reg) * 64'(mul_b_reg);

    // angle rounding: add one half, keep the integer part, apply the sign
    always_comb
    begin
        rnd         = prod_reg + ROUND_HALF;
        steps33     = cmd_reg.angle_neg ? -$signed({1'b0, rnd[63:32]})
                                        : $signed({1'b0, rnd[63:32]});
        angle_steps = POSITION_BITS'(steps33);
    end

    // allowance and burst length
    always_comb
    begin
        q_digit   = prod_reg[DIV_SHIFT +: DIGIT_BITS];
        allow     = quot_reg + 64'(frac_reg);
        n_raw     = allow[63:16];
        lim       = (burst_eff > 7'(MAX_BURST)) ? BURST_BITS'(MAX_BURST)
                                                : BURST_BITS'(burst_eff);
        n_lim     = (n_raw > 48'(lim)) ? lim : BURST_BITS'(n_raw);
        fwd       = (target_reg > pos_reg);
        diff      = (POSITION_BITS + 1)'(target_reg) - (POSITION_BITS + 1)'(pos_reg);
        dist_left = fwd ? diff : -diff;
        elapsed   = cmd_reg.now_ms - last_time_reg;
    end

    // one step of the burst
    always_comb
    begin
        step_pos = dir_reg ? pos_reg + POSITION_BITS'(1) : pos_reg - POSITION_BITS'(1);
        fin      = (cnt_reg == BURST_BITS'(1));
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        frac_next      = frac_reg;
        last_time_next = last_time_reg;
        dir_next       = dir_reg;
        en_next        = en_reg;
        cmd_next       = cmd_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        x_next         = x_reg;
        quot_next      = quot_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        cmd_pop        = 1'b0;
        res_wr         = 1'b0;
        res_word       = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = BK_START;
                end
            end

            BK_START:
            begin
                unique case (cmd_reg.op)
                    FUNC_TICK:
                    begin
                        last_time_next = cmd_reg.now_ms;
                        if (last_time_reg == '0)
                        begin
                            state_next = BK_STATUS;
                        end
                        else if (elapsed == '0 || target_reg == pos_reg)
                        begin
                            if (target_reg == pos_reg)
                            begin
                                en_next = 1'b0;
                            end
                            state_next = BK_STATUS;
                        end
                        else
                        begin
                            mul_a_next = rate_eff;
                            mul_b_next = elapsed;
                            state_next = BK_TMUL;
                        end
                    end
                    FUNC_SET_TARGET,
                    FUNC_SET_POSITION:
                    begin
                        mul_a_next = cmd_reg.angle_mag;
                        mul_b_next = spd_eff;
                        state_next = BK_AMUL;
                    end
                    FUNC_STOP:
                    begin
                        target_next = pos_reg;
                        frac_next   = '0;
                        en_next     = 1'b0;
                        state_next  = BK_STATUS;
                    end
                    default:
                    begin
                        state_next = BK_STATUS;
                    end
                endcase
            end

            BK_AMUL:
            begin
                state_next = BK_ANGLE;
            end

            BK_ANGLE:
            begin
                if (cmd_reg.op == FUNC_SET_TARGET)
                begin
                    target_next = angle_steps;
                    if (angle_steps != pos_reg)
                    begin
                        en_next = 1'b1;
                    end
                end
                else
                begin
                    pos_next       = angle_steps;
                    target_next    = angle_steps;
                    frac_next      = '0;
                    last_time_next = cmd_reg.now_ms;
                    en_next        = 1'b0;
                end
                state_next = BK_STATUS;
            end

            BK_TMUL:
            begin
                state_next = BK_DLOAD;
            end

            BK_DLOAD:
            begin
                dvd_next   = prod_reg;
                rem_next   = '0;
                quot_next  = '0;
                dig_next   = DIGIT_CNT_BITS'(NUM_DIGITS - 1);
                state_next = BK_DSET;
            end

            // next digit of the dividend under the running remainder
            BK_DSET:
            begin
                x_next     = {rem_reg, dvd_reg[63 -: DIGIT_BITS]};
                dvd_next   = dvd_reg << DIGIT_BITS;
                mul_a_next = 32'(x_next);
                mul_b_next = DIV_RECIP;
                state_next = BK_DWAIT;
            end

            BK_DWAIT:
            begin
                state_next = BK_DSTEP;
            end

            BK_DSTEP:
            begin
                quot_next = {quot_reg[63-DIGIT_BITS:0], q_digit};
                rem_next  = REM_BITS'(x_reg - DIV_X_BITS'(q_digit) * DIV_X_BITS'(RATE_DIVISOR));
                if (dig_reg == '0)
                begin
                    state_next = BK_ALLOW;
                end
                else
                begin
                    dig_next   = dig_reg - DIGIT_CNT_BITS'(1);
                    state_next = BK_DSET;
                end
            end

            BK_ALLOW:
            begin
                frac_next = allow[15:0];
                if (n_raw == '0)
                begin
                    state_next = BK_STATUS;
                end
                else
                begin
                    cnt_next   = (dist_left < (POSITION_BITS + 1)'(n_lim))
                                 ? BURST_BITS'(dist_left) : n_lim;
                    dir_next   = fwd;
                    en_next    = 1'b1;
                    state_next = BK_BURST;
                end
            end

            // one step word per cycle while the result queue has room
            BK_BURST:
            begin
                if (!res_full)
                begin
                    res_wr                  = 1'b1;
                    pos_next                = step_pos;
                    if (fin && step_pos == target_reg)
                    begin
                        en_next = 1'b0;
                    end
                    res_word.step           = 1'b1;
                    res_word.direction      = dir_reg;
                    res_word.enable         = en_next;
                    res_word.position_steps = step_pos;
                    res_word.last           = fin;
                    cnt_next                = cnt_reg - BURST_BITS'(1);
                    if (fin)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end

            BK_STATUS:
            begin
                if (!res_full)
                begin
                    res_wr                  = 1'b1;
                    res_word.step           = 1'b0;
                    res_word.direction      = dir_reg;
                    res_word.enable         = en_reg;
                    res_word.position_steps = pos_reg;
                    res_word.last           = 1'b1;
                    state_next              = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign status.idle     = (state_reg == BK_IDLE);
    assign status.in_burst = (state_reg == BK_BURST);

    // control and axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pos_reg       <= '0;
            target_reg    <= '0;
            frac_reg      <= '0;
            last_time_reg <= '0;
            dir_reg       <= 1'b0;
            en_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            frac_reg      <= frac_next;
            last_time_reg <= last_time_next;
            dir_reg       <= dir_next;
            en_reg        <= en_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        x_reg     <= x_next;
        quot_reg  <= quot_next;
        dig_reg   <= dig_next;
        cnt_reg   <= cnt_next;
    end

endmodule

// File: design/ssdg_outq.sv
// result queue: two-entry queue between back end and receiver
// uses ssdg_pkg
module ssdg_outq
    import ssdg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wr_word,
    output logic    wr_full,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    result_t                 q_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_PTR_BITS:0]   count_reg, count_next;
    logic                    wr_ok;
    logic                    pop_ok;

    assign wr_full = (count_reg == (OUT_PTR_BITS + 1)'(OUT_DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_ok   = wr && !wr_full;
    assign pop_ok  = pop && !empty;
    assign result  = q_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ok ? wr_ptr_reg + OUT_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + OUT_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + (OUT_PTR_BITS + 1)'(wr_ok) - (OUT_PTR_BITS + 1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            q_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// File: dv/stepper_step_dir_generator_tb.sv
// self-checking testbench for the stepper step/direction generator
// depends on ssdg_pkg and the stepper_step_dir_generator rtl
`timescale 1ns / 100ps

module stepper_step_dir_generator_tb;
    import ssdg_pkg::*;

    localparam int SETTLE          = 40;
    localparam int NPHASE          = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int LIMIT           = 2_000_000;
    localparam int MAX_SHOWN       = 50;

    // one register setting plus the angle span used for random words
    typedef struct packed {
        logic [31:0] spd;
        logic [31:0] rate;
        logic [6:0]  burst;
        logic [31:0] span;
    } phase_t;

    // one directed word, with a hand-typed status result where it is obvious
    typedef struct packed {
        item_t   w;
        bit      typed;
        result_t want;
    } script_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    item_t                    word_in;
    logic                     empty;
    logic                     pop;
    result_t                  word_out;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // axis state and register copies of the predictor
    longint      pos_cnt;
    longint      tgt_cnt;
    logic [15:0] frac_q16;
    logic [31:0] last_ms;
    logic        dir_line;
    logic        en_line;
    logic [31:0] spd_q16;
    logic [31:0] rate_q16;
    logic [6:0]  burst_max;

    result_t     due_words[$];
    script_row_t script[$];
    logic [31:0] cur_ms;
    bit          idle_on = 1'b1;
    int          err_count;
    int          words_in;
    int          n_results;
    int          n_steps;
    int          cycle_count;

    stepper_step_dir_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (word_in),
        .empty   (empty),
        .pop     (pop),
        .result  (word_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    task automatic note_error(string msg);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // queue one expected result from the current axis state
    function automatic void queue_word(bit stp, bit lst);
        result_t r;
        r.step           = stp;
        r.direction      = dir_line;
        r.enable         = en_line;
        r.position_steps = POSITION_BITS'(pos_cnt);
        r.last           = lst;
        due_words.push_back(r);
    endfunction

    // angle in signed q16.16 degrees to steps, rounded half away from zero
    function automatic longint angle_steps(logic [31:0] a);
        logic [31:0] m32;
        logic [63:0] spd;
        logic [63:0] s;
        m32 = a[31] ? (~a + 32'd1) : a;
        spd = (spd_q16 != 0) ? {32'd0, spd_q16} : 64'd65536;
        s = ({32'd0, m32} * spd + 64'h8000_0000) >> 32;
        return a[31] ? -longint'(s) : longint'(s);
    endfunction

    // advance the axis by one input word and queue the results it causes
    function automatic void advance_axis(item_t w);
        logic [31:0] el;
        logic [63:0] rate;
        logic [63:0] allow;
        logic [63:0] n;
        logic [63:0] lim;
        logic [63:0] dist_left;
        bit          fwd;
        bit          fin;
        case (w.func)
            FUNC_TICK:
            begin
                // first tick only records the time
                if (last_ms == 0) begin
                    last_ms = w.now_ms;
                    queue_word(1'b0, 1'b1);
                    return;
                end
                el = w.now_ms - last_ms;
                last_ms = w.now_ms;
                if (el == 0 || tgt_cnt == pos_cnt) begin
                    if (tgt_cnt == pos_cnt)
                        en_line = 1'b0;
                    queue_word(1'b0, 1'b1);
                    return;
                end
                // allowance in q16: rate times elapsed over 1000 plus carried fraction
                rate = (rate_q16 != 0) ? {32'd0, rate_q16} : 64'd65536;
                allow = (rate * {32'd0, el}) / 64'd1000 + {48'd0, frac_q16};
                n = allow >> 16;
                frac_q16 = allow[15:0];
                if (n == 0) begin
                    queue_word(1'b0, 1'b1);
                    return;
                end
                // clip to the burst limit and to the distance left
                lim = (burst_max != 0) ? {57'd0, burst_max} : 64'd1;
                if (lim > MAX_BURST)
                    lim = MAX_BURST;
                if (n > lim)
                    n = lim;
                fwd = tgt_cnt > pos_cnt;
                dist_left = fwd ? 64'(tgt_cnt - pos_cnt) : 64'(pos_cnt - tgt_cnt);
                if (n > dist_left)
                    n = dist_left;
                dir_line = fwd;
                en_line = 1'b1;
                for (int k = 0; k < int'(n); k++) begin
                    pos_cnt += fwd ? 1 : -1;
                    fin = (k + 1 == int'(n));
                    if (fin && pos_cnt == tgt_cnt)
                        en_line = 1'b0;
                    queue_word(1'b1, fin);
                end
                return;
            end
            FUNC_SET_TARGET:
            begin
                tgt_cnt = angle_steps(w.angle_deg_q16);
                if (tgt_cnt != pos_cnt)
                    en_line = 1'b1;
            end
            FUNC_SET_POSITION:
            begin
                pos_cnt = angle_steps(w.angle_deg_q16);
                tgt_cnt = pos_cnt;
                frac_q16 = '0;
                last_ms = w.now_ms;
                en_line = 1'b0;
            end
            default:
            begin
                tgt_cnt = pos_cnt;
                frac_q16 = '0;
                en_line = 1'b0;
            end
        endcase
        queue_word(1'b0, 1'b1);
    endfunction

    function automatic void add_row(func_t f, logic [31:0] t, logic [31:0] a, bit typed = 0,
                                    bit dir = 0, bit en = 0, longint pos = 0);
        script_row_t r;
        r.w.func               = f;
        r.w.now_ms             = t;
        r.w.angle_deg_q16      = a;
        r.typed                = typed;
        r.want.step            = 1'b0;
        r.want.direction       = dir;
        r.want.enable          = en;
        r.want.position_steps  = POSITION_BITS'(pos);
        r.want.last            = 1'b1;
        script.push_back(r);
    endfunction

    function automatic phase_t phase_setting(int p);
        case (p)
            0:       return '{32'h0010_0000, 32'h0005_0000, 7'd8,   32'h0008_0000};
            1:       return '{32'h0000_0001, 32'hFFFF_FFFF, 7'd64,  32'h7FFF_FFFF};
            2:       return '{32'hFFFF_FFFF, 32'h0000_0001, 7'd1,   32'h0000_0010};
            3:       return '{32'h0000_0000, 32'h0000_0000, 7'd0,   32'h0002_0000};
            4:       return '{32'd200000,    32'h0012_3456, 7'd127, 32'h0004_0000};
            default: return '{32'h0003_3039, 32'h0028_0000, 7'd64,  32'h0001_0000};
        endcase
    endfunction

    // mostly ticks, with some target moves, stops, position resets and noise
    function automatic item_t random_word(logic [31:0] span);
        item_t       w;
        int          r;
        logic [31:0] mag;
        r = $urandom_range(0, 99);
        mag = $urandom_range(0, span);
        w.angle_deg_q16 = $urandom_range(0, 1) ? -mag : mag;
        w.now_ms = cur_ms;
        if (r < 60) begin
            w.func = FUNC_TICK;
            cur_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 25);
            w.now_ms = cur_ms;
        end
        else if (r < 75)
            w.func = FUNC_SET_TARGET;
        else if (r < 82)
            w.func = FUNC_SET_POSITION;
        else if (r < 88)
            w.func = FUNC_STOP;
        else begin
            w.func = 2'($urandom_range(0, 3));
            w.now_ms = $urandom;
            w.angle_deg_q16 = $urandom;
            if (w.func == FUNC_TICK || w.func == FUNC_SET_POSITION)
                cur_ms = w.now_ms;
        end
        return w;
    endfunction

    // drive one word until taken, then predict its results
    task automatic send_word(item_t w, bit typed, result_t want);
        int before_n;
        @(negedge clk);
        push <= 1'b1;
        word_in <= w;
        do @(posedge clk); while (full);
        before_n = due_words.size();
        advance_axis(w);
        if (typed) begin
            while (due_words.size() > before_n)
                void'(due_words.pop_back());
            due_words.push_back(want);
        end
        words_in++;
    endtask

    task automatic gap(int n);
        repeat (n) begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // hold the input until every expected result is out
    task automatic drain(int settle);
        @(negedge clk);
        push <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_addr_t idx, logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_STEPS_PER_DEGREE: spd_q16 = v;
            REG_STEPS_PER_MS:     rate_q16 = v;
            REG_MAX_STEPS:        burst_max = v[6:0];
            default:              ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: pop, with random stall bursts except in the last phase
    initial
    begin : sink
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end
            else begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    stall = $urandom_range(1, 18);
            end
        end
    end

    // compare each popped word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        string   bad;
        if (rst_n && pop && !empty) begin
            n_results++;
            if (word_out.step)
                n_steps++;
            if (due_words.size() == 0)
                note_error("result word with nothing expected");
            else begin
                want = due_words.pop_front();
                bad = "";
                if (word_out.step !== want.step)
                    bad = {bad, " step"};
                if (word_out.direction !== want.direction)
                    bad = {bad, " direction"};
                if (word_out.enable !== want.enable)
                    bad = {bad, " enable"};
                if (word_out.position_steps !== want.position_steps)
                    bad = {bad, " position"};
                if (word_out.last !== want.last)
                    bad = {bad, " last"};
                if (bad != "")
                    note_error($sformatf(
                        "result %0d wrong:%s got %b/%b/%b/%0d/%b want %b/%b/%b/%0d/%b",
                        n_results, bad, word_out.step, word_out.direction, word_out.enable,
                        word_out.position_steps, word_out.last, want.step, want.direction,
                        want.enable, want.position_steps, want.last));
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stepper_step_dir_generator_tb: done, errors");
        $finish;
    end

    initial
    begin : main
        phase_t ph;
        rst_n    = 1'b0;
        push     = 1'b0;
        word_in  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        pos_cnt  = 0;
        tgt_cnt  = 0;
        frac_q16 = '0;
        last_ms  = '0;
        dir_line = 1'b0;
        en_line  = 1'b0;
        spd_q16  = SPD_RESET;
        rate_q16 = RATE_RESET;
        burst_max = BURST_RESET;
        cur_ms   = 32'd100;

        // directed words at the reset register values
        add_row(FUNC_TICK, 0, 0, 1, 0, 0, 0);
        add_row(FUNC_TICK, 5, 0, 1, 0, 0, 0);
        add_row(FUNC_SET_TARGET, 5, 32'h0001_8000, 1, 0, 1, 0);
        add_row(FUNC_TICK, 5, 0, 1, 0, 1, 0);
        add_row(FUNC_TICK, 1005, 0);
        add_row(FUNC_TICK, 1_001_005, 0);
        add_row(FUNC_TICK, 2_001_005, 0);
        add_row(FUNC_TICK, 2_001_006, 0);
        add_row(FUNC_SET_TARGET, 0, 32'h8000_0000, 1, 1, 1, 2);
        add_row(FUNC_STOP, 0, 0, 1, 1, 0, 2);
        add_row(FUNC_SET_POSITION, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1, 0, 32768);
        add_row(FUNC_SET_TARGET, 0, 32'h7FFF_0000);
        add_row(FUNC_TICK, 32'h7FFF_FFFF, 0);
        add_row(FUNC_SET_POSITION, 0, 32'hFFFF_8000, 1, 0, 0, -1);
        add_row(FUNC_SET_TARGET, 0, 32'h0000_7FFF);
        add_row(FUNC_TICK, 3000, 0, 1, 0, 1, -1);
        add_row(FUNC_TICK, 1_003_000, 0);
        add_row(FUNC_STOP, 0, 0);
        add_row(FUNC_TICK, 32'hFFFF_FFFF, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (idle_on && $urandom_range(0, 3) == 0)
                gap($urandom_range(1, 18));
            send_word(script[i].w, script[i].typed, script[i].want);
        end

        // random words under several register settings, last one without idling
        for (int p = 0; p < NPHASE; p++) begin
            ph = phase_setting(p);
            drain(SETTLE);
            cfg_write(REG_STEPS_PER_DEGREE, ph.spd);
            cfg_write(REG_STEPS_PER_MS, ph.rate);
            cfg_write(REG_MAX_STEPS, {25'd0, ph.burst});
            idle_on = (p != NPHASE - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (idle_on && i == ITEMS_PER_PHASE / 2)
                    drain(0);
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap($urandom_range(1, 18));
                send_word(random_word(ph.span), 1'b0, '0);
            end
        end

        drain(SETTLE);
        $display("run covered %0d input words over %0d register settings plus reset values",
                 words_in, NPHASE);
        $display("%0d result words checked, %0d of them steps, %0d mismatches",
                 n_results, n_steps, err_count);
        if (err_count == 0)
            $display("stepper_step_dir_generator_tb: done, clean");
        else
            $display("stepper_step_dir_generator_tb: done, errors");
        $finish;
    end

endmodule

// File: stepper_step_dir_generator.f
+incdir+design
design/ssdg_pkg.sv
design/ssdg_front.sv
design/ssdg_back.sv
design/ssdg_outq.sv
design/stepper_step_dir_generator.sv
dv/stepper_step_dir_generator_tb.sv
